### rtl/core/mersenne_twister_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// MT19937 generator assertion macros
// Shared concurrent assertion wrappers for the generator checker.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_ASSERT_SVH

// Assert a property on a given clock, ignored while reset is low.
`define MTG_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Assert a property on the usual clock and reset names.
`define MTG_ASSERT(label, prop, msg) \
  `MTG_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/mtg_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 generator package
// Constants, command and state types shared by the generator modules.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned StateWords   = 624;
  localparam int unsigned MiddleOffset = 397;
  localparam int unsigned IdxW         = $clog2(StateWords + 1);
  localparam int unsigned InDataW      = 8;

  localparam logic [WordW-1:0] MtMatrix  = 32'h9908_B0DF;
  localparam logic [WordW-1:0] InitMul   = 32'd1812433253;
  localparam logic [WordW-1:0] TemperB   = 32'h9D2C_5680;
  localparam logic [WordW-1:0] TemperC   = 32'hEFC6_0000;
  localparam logic [WordW-1:0] ResetSeed = 32'h0123_4567;

  localparam int unsigned CmdQueueDepth = 2;

  typedef enum logic {
    CMD_DRAW,
    CMD_RESEED
  } cmd_e;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } cmd_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_INIT,
    ST_FILL_MUL,
    ST_FILL_ADD,
    ST_DRAW,
    ST_DRAW_RD,
    ST_TW_START,
    ST_TW_LOAD,
    ST_TW_RD,
    ST_TW_WR
  } eng_state_e;

endpackage

### rtl/core/mtg_ram.sv
// ----------------------------------------------------------------------------
// MT19937 generator RAM
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/core/mtg_front.sv
// ----------------------------------------------------------------------------
// MT19937 generator front end
// Accepts input words, classifies them as draw or reseed, and queues them.
// ----------------------------------------------------------------------------
module mtg_front #(
  parameter int unsigned QueueDepth = mtg_pkg::CmdQueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mtg_pkg::InDataW-1:0] s_axis_tdata,   // [0] reseed
  output mtg_pkg::cmd_req_t           cmd_o,
  input  logic                        cmd_pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  mtg_pkg::cmd_e   queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  mtg_pkg::cmd_e   in_cmd;

  assign s_axis_tready = (count_q != CntW'(QueueDepth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_pop_i && (count_q != '0);
  assign in_cmd        = s_axis_tdata[0] ? mtg_pkg::CMD_RESEED : mtg_pkg::CMD_DRAW;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= in_cmd;
    end
  end

  assign cmd_o.valid = (count_q != '0);
  assign cmd_o.cmd   = queue_q[rd_ptr_q];

endmodule

### rtl/core/mtg_engine.sv
// ----------------------------------------------------------------------------
// MT19937 generator engine
// Seeds, twists and reads the state store; tempers words into the output.
// ----------------------------------------------------------------------------
module mtg_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mtg_pkg::WordW-1:0] seed_i,
  input  mtg_pkg::cmd_req_t         cmd_i,
  output logic                      cmd_pop_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [mtg_pkg::WordW-1:0] m_axis_tdata    // [31:0] random_word
);

  localparam int unsigned WordW  = mtg_pkg::WordW;
  localparam int unsigned IdxW   = mtg_pkg::IdxW;
  localparam int unsigned AddrW  = $clog2(mtg_pkg::StateWords);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(mtg_pkg::StateWords - 1);
  localparam logic [IdxW-1:0] EndPos  = IdxW'(mtg_pkg::StateWords);
  localparam logic [IdxW-1:0] WrapPt  = IdxW'(mtg_pkg::StateWords - mtg_pkg::MiddleOffset);
  localparam logic [IdxW-1:0] MidOff  = IdxW'(mtg_pkg::MiddleOffset);

  function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] w);
    logic [WordW-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtg_pkg::TemperB);
    y = y ^ ((y << 15) & mtg_pkg::TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  mtg_pkg::eng_state_e state_q, state_d;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic             from_cmd_q, from_cmd_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] prev_q, prev_d;
  logic [WordW-1:0] prod_q;
  logic [WordW-1:0] cur_q;
  logic [WordW-1:0] out_data_q;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [AddrW-1:0] raddr_a, raddr_b;
  logic [WordW-1:0] rdata_a, rdata_b;

  logic             can_pop;
  logic             at_end;
  logic [IdxW-1:0]  nxt_idx, mid_idx;
  logic [WordW-1:0] mixed;
  logic [2*WordW-1:0] prod_full;
  logic [WordW-1:0] fill_word;
  logic [WordW-1:0] tw_x, tw_mag, tw_word;

  assign can_pop = cmd_i.valid && (!out_valid_q || m_axis_tready);
  assign at_end  = (pos_q >= EndPos);

  // Twist addressing: next word wraps to 0, middle word wraps by the offset.
  assign nxt_idx = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign mid_idx = (idx_q < WrapPt) ? idx_q + MidOff : idx_q - WrapPt;

  assign mixed     = prev_q ^ (prev_q >> 30);
  assign prod_full = mtg_pkg::InitMul * mixed;
  assign fill_word = prod_q + WordW'(idx_q);

  assign tw_x    = {cur_q[WordW-1], rdata_a[WordW-2:0]};
  assign tw_mag  = (tw_x >> 1) ^ (tw_x[0] ? mtg_pkg::MtMatrix : '0);
  assign tw_word = rdata_b ^ tw_mag;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtg_pkg::ST_IDLE: begin
        if (can_pop) begin
          if (cmd_i.cmd == mtg_pkg::CMD_RESEED) begin
            state_d = mtg_pkg::ST_FILL_INIT;
          end else if (at_end) begin
            state_d = mtg_pkg::ST_TW_START;
          end else begin
            state_d = mtg_pkg::ST_DRAW_RD;
          end
        end
      end
      mtg_pkg::ST_FILL_INIT: state_d = mtg_pkg::ST_FILL_MUL;
      mtg_pkg::ST_FILL_MUL:  state_d = mtg_pkg::ST_FILL_ADD;
      mtg_pkg::ST_FILL_ADD: begin
        if (idx_q == LastIdx) begin
          state_d = from_cmd_q ? mtg_pkg::ST_TW_START : mtg_pkg::ST_IDLE;
        end else begin
          state_d = mtg_pkg::ST_FILL_MUL;
        end
      end
      mtg_pkg::ST_DRAW:     state_d = mtg_pkg::ST_DRAW_RD;
      mtg_pkg::ST_DRAW_RD:  state_d = mtg_pkg::ST_IDLE;
      mtg_pkg::ST_TW_START: state_d = mtg_pkg::ST_TW_LOAD;
      mtg_pkg::ST_TW_LOAD:  state_d = mtg_pkg::ST_TW_RD;
      mtg_pkg::ST_TW_RD:    state_d = mtg_pkg::ST_TW_WR;
      mtg_pkg::ST_TW_WR: begin
        state_d = (idx_q == LastIdx) ? mtg_pkg::ST_DRAW : mtg_pkg::ST_TW_RD;
      end
      default: state_d = mtg_pkg::ST_IDLE;
    endcase
  end

  // Outputs: store ports and queue pop
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AddrW-1:0];
    ram_wdata = fill_word;
    raddr_a   = pos_q[AddrW-1:0];
    raddr_b   = mid_idx[AddrW-1:0];
    cmd_pop_o = 1'b0;
    unique case (state_q)
      mtg_pkg::ST_IDLE: begin
        cmd_pop_o = can_pop;
      end
      mtg_pkg::ST_FILL_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = prev_q;
      end
      mtg_pkg::ST_FILL_ADD: begin
        ram_we = 1'b1;
      end
      mtg_pkg::ST_TW_START: begin
        raddr_a = '0;
      end
      mtg_pkg::ST_TW_RD: begin
        raddr_a = nxt_idx[AddrW-1:0];
      end
      mtg_pkg::ST_TW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = tw_word;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_comb begin
    idx_d       = idx_q;
    pos_d       = pos_q;
    from_cmd_d  = from_cmd_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      mtg_pkg::ST_IDLE: begin
        if (can_pop && (cmd_i.cmd == mtg_pkg::CMD_RESEED)) begin
          prev_d     = seed_i;
          from_cmd_d = 1'b1;
        end
      end
      mtg_pkg::ST_FILL_INIT: idx_d = IdxW'(1);
      mtg_pkg::ST_FILL_ADD: begin
        prev_d = fill_word;
        idx_d  = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          pos_d      = EndPos;
          from_cmd_d = 1'b0;
        end
      end
      mtg_pkg::ST_DRAW_RD: begin
        out_valid_d = 1'b1;
        pos_d       = pos_q + 1'b1;
      end
      mtg_pkg::ST_TW_LOAD: idx_d = '0;
      mtg_pkg::ST_TW_WR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          pos_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtg_pkg::ST_FILL_INIT;
      idx_q       <= '0;
      pos_q       <= EndPos;
      from_cmd_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q      <= mtg_pkg::ResetSeed;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      from_cmd_q  <= from_cmd_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == mtg_pkg::ST_FILL_MUL) begin
      prod_q <= prod_full[WordW-1:0];
    end
    // Carry the old next word forward as the current word.
    if ((state_q == mtg_pkg::ST_TW_LOAD) || (state_q == mtg_pkg::ST_TW_WR)) begin
      cur_q <= rdata_a;
    end
    if (state_q == mtg_pkg::ST_DRAW_RD) begin
      out_data_q <= temper(rdata_a);
    end
  end

  mtg_ram #(
    .Width(WordW),
    .Depth(mtg_pkg::StateWords)
  ) u_mtg_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/core/mersenne_twister_generator_unit.sv
// ----------------------------------------------------------------------------
// MT19937 generator unit
// 32-bit Mersenne twister: seeds, twists and tempers one word per input word.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[0] reseed (1 = refill state from seed first)
// m_axis    out  tdata[31:0] random_word
// cfg       in   cfg_wdata_i seed, written when cfg_we_i is high
//
// A draw goes from queue to output register through one store read and one
// temper stage. Every 624th draw first twists the store, reading each word
// through the registered read port ahead of its write. A reseed refills
// the store first, each word through the seeding multiplier, then twists
// it. After reset the store is filled from the reset seed. A word waiting
// at the output stalls the engine; input words queue.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_unit #(
  parameter int unsigned QueueDepth = mtg_pkg::CmdQueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mtg_pkg::InDataW-1:0] s_axis_tdata,   // [0] reseed
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [mtg_pkg::WordW-1:0]   m_axis_tdata,   // [31:0] random_word
  input  logic                        cfg_we_i,
  input  logic [mtg_pkg::WordW-1:0]   cfg_wdata_i
);

  logic [mtg_pkg::WordW-1:0] seed_q;
  mtg_pkg::cmd_req_t         cmd_req;
  logic                      cmd_pop;

  // Hold the seed until the next write; a reseed word takes it up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mtg_pkg::ResetSeed;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  mtg_front #(
    .QueueDepth(QueueDepth)
  ) u_mtg_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .cmd_o        (cmd_req),
    .cmd_pop_i    (cmd_pop)
  );

  mtg_engine u_mtg_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .cmd_i        (cmd_req),
    .cmd_pop_o    (cmd_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

### rtl/core/mtg_checker.sv
// ----------------------------------------------------------------------------
// MT19937 generator checker
// Port-level assertions on output hold, word accounting and queue bounds, bound to the top.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_unit_assert.svh"

module mtg_checker #(
  parameter int unsigned QueueDepth = mtg_pkg::CmdQueueDepth
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [mtg_pkg::WordW-1:0] m_axis_tdata
);

  localparam int unsigned PendW = $clog2(QueueDepth + 3);

  logic [PendW-1:0] pend_q;
  logic             in_take, out_take;

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // Track words accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PendW'(in_take) - PendW'(out_take);
    end
  end

  `MTG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

  `MTG_ASSERT(a_out_needs_input, m_axis_tvalid |-> (pend_q != '0), "output word without accepted input")

  `MTG_ASSERT(a_pend_bound, (pend_q == PendW'(QueueDepth + 1)) |-> !s_axis_tready, "input accepted beyond queue and engine room")

endmodule

bind mersenne_twister_generator_unit mtg_checker #(
  .QueueDepth(QueueDepth)
) u_mtg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### tb/mersenne_twister_generator_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 generator checker
// Watches the input, output and seed ports of the generator, keeps its own
// copy of the 624-word store, predicts every tempered word and compares each
// output word with the oldest prediction.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_unit_checker
  import mtg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,   // [0] reseed
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [WordW-1:0]   m_axis_tdata,   // [31:0] random_word
  input  logic               cfg_we_i,
  input  logic [WordW-1:0]   cfg_wdata_i,
  output int                 pending_words,
  output int                 mismatch_count
);

  logic [WordW-1:0] mt_store [StateWords];
  int               mt_pos;
  logic [WordW-1:0] seed_q;
  logic [WordW-1:0] predicted_words [$];
  int               mismatches;

  function automatic void seed_store(input logic [WordW-1:0] s);
    logic [WordW-1:0] prev;
    mt_store[0] = s;
    for (int k = 1; k < StateWords; k++) begin
      prev        = mt_store[k-1];
      mt_store[k] = InitMul * (prev ^ (prev >> 30)) + WordW'(k);
    end
    mt_pos = StateWords;
  endfunction

  function automatic void twist_store();
    logic [WordW-1:0] x;
    logic [WordW-1:0] xa;
    int               nxt;
    int               mid;
    for (int k = 0; k < StateWords; k++) begin
      nxt = (k + 1) % StateWords;
      mid = (k + MiddleOffset) % StateWords;
      x   = {mt_store[k][31], mt_store[nxt][30:0]};
      xa  = x >> 1;
      if (x[0]) begin
        xa = xa ^ MtMatrix;
      end
      mt_store[k] = mt_store[mid] ^ xa;
    end
    mt_pos = 0;
  endfunction

  function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] w);
    logic [WordW-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [WordW-1:0] draw_word(input logic reseed);
    logic [WordW-1:0] y;
    if (reseed) begin
      seed_store(seed_q);
    end
    if (mt_pos >= StateWords) begin
      twist_store();
    end
    y      = mt_store[mt_pos];
    mt_pos = mt_pos + 1;
    return temper(y);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [WordW-1:0] want;
    if (!rst_ni) begin
      seed_q = ResetSeed;
      seed_store(ResetSeed);
      predicted_words.delete();
      mismatches      = 0;
      pending_words  <= 0;
      mismatch_count <= 0;
    end else begin
      // Retire the output word first: it always belongs to an older input.
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_words.size() == 0) begin
          $display("%0t: unexpected random word: expected none, actual %08h",
                   $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = predicted_words.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: random word mismatch: expected %08h, actual %08h",
                     $time, want, m_axis_tdata);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_words.push_back(draw_word(s_axis_tdata[0]));
      end
      // Seed is only stored; it takes effect at the next reseed word.
      if (cfg_we_i) begin
        seed_q = cfg_wdata_i;
      end
      pending_words  <= predicted_words.size();
      mismatch_count <= mismatches;
    end
  end

endmodule

### tb/tb_mersenne_twister_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives draw and reseed words with random gaps and output stalls, writes
// the seed between phases, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator_unit;
  import mtg_pkg::*;

  localparam int unsigned RandomWords = 1600;
  localparam int unsigned Phases      = 8;
  localparam int unsigned TailCycles  = 16;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata  = '0;   // [0] reseed
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b1;
  logic [WordW-1:0]   m_axis_tdata;         // [31:0] random_word
  logic               cfg_we_i      = 1'b0;
  logic [WordW-1:0]   cfg_wdata_i   = '0;
  int                 pending_words;
  int                 mismatch_count;
  bit                 idle_on       = 1'b0;

  mersenne_twister_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  mersenne_twister_generator_unit_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pending_words  (pending_words),
    .mismatch_count (mismatch_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Sink side: stall the output in short random bursts while idling is on.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("mersenne_twister_generator_unit verification failed");
    $finish;
  end

  // Present one word; upper tdata bits are noise the block must ignore.
  task automatic send_word(input logic reseed);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {(InDataW-1)'($urandom()), reseed};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold off the input until every predicted word has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  task automatic write_seed(input logic [WordW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] pick_seed();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return ResetSeed;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Draw from the reset seed, then reseed from the same seed.
    repeat (4) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    drain();

    // New seed is only stored until a reseed word arrives.
    write_seed('0);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    drain();

    write_seed('1);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);
    drain();

    write_seed(32'h8000_0000);
    send_word(1'b1);
    send_word(1'b0);
    drain();

    write_seed(32'h0000_0001);
    send_word(1'b1);
    repeat (3) send_word(1'b0);

    // Random phases; reseeds are rare so draws run past the twist point.
    for (int p = 0; p < Phases; p++) begin
      drain();
      write_seed(pick_seed());
      idle_on <= (p < Phases - 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < RandomWords / Phases; n++) begin
        send_word((n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 149) == 0));
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("mersenne_twister_generator_unit verification clean");
    end else begin
      $display("mersenne_twister_generator_unit verification failed");
    end
    $finish;
  end

endmodule
